FILE: sv/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// Shared constants, register codes and the item type that moves along the
// cell chain of the local alignment score block.
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int MAX_QUERY  = 64;
  localparam int MAX_TARGET = 4095;
  localparam int SCORE_MAX  = 1023;

  localparam int QIDX_W  = $clog2(MAX_QUERY);
  localparam int QLEN_W  = $clog2(MAX_QUERY + 1);
  localparam int COL_W   = $clog2(MAX_TARGET + 1);
  localparam int SCORE_W = $clog2(SCORE_MAX + 1);
  localparam int SUM_W   = SCORE_W + 2;
  localparam int SYM_W   = 8;

  localparam logic signed [SUM_W-1:0] SCORE_CAP = SUM_W'(SCORE_MAX);

  // register indexes on the configuration port
  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  localparam logic [3:0] MATCH_RESET    = 4'd1;
  localparam logic [4:0] MISMATCH_RESET = 5'b11110;
  localparam logic [4:0] GAP_RESET      = 5'b11100;

  typedef struct packed {
    logic [3:0] match_score;
    logic [4:0] mismatch_score;
    logic [4:0] gap_score;
  } las_cfg_t;

  // one item on the chain: query load or target column, plus the best cell
  // token that is merged cell by cell on the closing target item
  typedef struct packed {
    logic               vld;
    logic               tgt;
    logic               clr;
    logic               wr;
    logic [QIDX_W-1:0]  idx;
    logic [SYM_W-1:0]   sym;
    logic               last;
    logic [COL_W-1:0]   col;
    logic [SCORE_W-1:0] up;
    logic [SCORE_W-1:0] bscore;
    logic [QLEN_W-1:0]  brow;
    logic [COL_W-1:0]   bcol;
  } las_item_t;

endpackage

FILE: sv/local_alignment_score.sv
// ----------------------------------------------------------------------------
// local_alignment_score
// Smith-Waterman local alignment score, linear gap, on a chain of row cells.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser = 0 loads a query character, s_tuser = 1
// streams a target character, s_tlast closes the query or the target. Query
// characters beyond 64 are dropped. Each target character walks down a chain
// of 64 row cells, one cell per cycle while the chain runs, and fills one
// column of the matrix. One item is taken every cycle while no result waits
// on a stalled m_tready; the rate is set by the single cell stage each item
// spends in every row. The closing target item collects the best cell as it
// passes the rows and leaves a result on m_*: best score, end row and end
// column, passed on through the entry register, the 64 cells and then the
// output register.
// Scores are set over the APB port (match, mismatch, gap at 0x0, 0x4, 0x8).
// Reset clears the query, the column scores and the best cell, and loads the
// default scores; there is no clearing pass. s_tready is low during reset.
// While a result waits on a stalled m_tready, the whole chain holds and
// s_tready is low; it resumes in the cycle the result is taken.
// ----------------------------------------------------------------------------
module local_alignment_score (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tuser,   // [0] cmd
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [9:0] best_score, [16:10] end_row, [28:17] end_col
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import las_pkg::*;

  las_cfg_t  cfg;
  logic      en;
  logic      accept;
  las_item_t chain [MAX_QUERY+1];
  las_item_t tail;

  logic [SCORE_W-1:0] res_score;
  logic [QLEN_W-1:0]  res_row;
  logic [COL_W-1:0]   res_col;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_score    <= MATCH_RESET;
      cfg.mismatch_score <= MISMATCH_RESET;
      cfg.gap_score      <= GAP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MATCH:    cfg.match_score    <= pwdata[3:0];
        REG_MISMATCH: cfg.mismatch_score <= pwdata[4:0];
        REG_GAP:      cfg.gap_score      <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MATCH:    prdata = {28'd0, cfg.match_score};
      REG_MISMATCH: prdata = {{27{cfg.mismatch_score[4]}}, cfg.mismatch_score};
      REG_GAP:      prdata = {{27{cfg.gap_score[4]}}, cfg.gap_score};
      default:      prdata = '0;
    endcase
  end

  // the chain holds only while a result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;
  assign accept   = s_tvalid && s_tready;

  las_feed u_feed (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .accept (accept),
    .cmd    (s_tuser),
    .symbol (s_tdata),
    .last   (s_tlast),
    .item   (chain[0])
  );

  for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
    las_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_idx (QIDX_W'(g)),
      .cfg      (cfg),
      .in_item  (chain[g]),
      .out_item (chain[g+1])
    );
  end

  assign tail = chain[MAX_QUERY];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      if (tail.vld && tail.tgt && tail.last) begin
        m_tvalid  <= 1'b1;
        res_score <= tail.bscore;
        res_row   <= tail.brow;
        res_col   <= tail.bcol;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {3'd0, res_col, res_row, res_score};

endmodule

FILE: sv/las_cell.sv
// ----------------------------------------------------------------------------
// las_cell
// One query row of the score matrix: holds its query character, its score
// from the previous column and its own best cell; hands the item on.
// ----------------------------------------------------------------------------
module las_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [las_pkg::QIDX_W-1:0] cell_idx,
  input  las_pkg::las_cfg_t         cfg,
  input  las_pkg::las_item_t        in_item,
  output las_pkg::las_item_t        out_item
);
  import las_pkg::*;

  logic [SYM_W-1:0]   qchar;
  logic               qvalid;
  logic [SCORE_W-1:0] hleft;
  logic [SCORE_W-1:0] diag;
  logic [SCORE_W-1:0] lbest;
  logic [COL_W-1:0]   lcol;

  logic [5:0]               sim;
  logic signed [SUM_W-1:0]  sim_x, gap_x, diag_x, up_x, left_x;
  logic signed [SUM_W-1:0]  c_diag, c_up, c_left, best_v;
  logic [SCORE_W-1:0]       h;
  logic                     is_tgt, active;
  logic [SCORE_W-1:0]       lbest_next;
  logic [COL_W-1:0]         lcol_next;
  logic [QLEN_W-1:0]        row;
  las_item_t                out_next;

  always_comb begin
    sim    = (qchar == in_item.sym) ? {2'b00, cfg.match_score}
                                    : {cfg.mismatch_score[4], cfg.mismatch_score};
    sim_x  = {{(SUM_W-6){sim[5]}}, sim};
    gap_x  = {{(SUM_W-5){cfg.gap_score[4]}}, cfg.gap_score};
    diag_x = {{(SUM_W-SCORE_W){1'b0}}, diag};
    up_x   = {{(SUM_W-SCORE_W){1'b0}}, in_item.up};
    left_x = {{(SUM_W-SCORE_W){1'b0}}, hleft};
    c_diag = diag_x + sim_x;
    c_up   = up_x + gap_x;
    c_left = left_x + gap_x;

    best_v = '0;
    if (c_diag > best_v) best_v = c_diag;
    if (c_up > best_v) best_v = c_up;
    if (c_left > best_v) best_v = c_left;
    h = (best_v > SCORE_CAP) ? SCORE_W'(SCORE_MAX) : best_v[SCORE_W-1:0];

    is_tgt = in_item.vld && in_item.tgt;
    active = is_tgt && qvalid;

    // strict compare keeps the earliest column of this row
    lbest_next = lbest;
    lcol_next  = lcol;
    if (active && (h > lbest)) begin
      lbest_next = h;
      lcol_next  = in_item.col;
    end

    row      = QLEN_W'(cell_idx) + QLEN_W'(1);
    out_next = in_item;
    out_next.up = h;
    // incoming token comes from smaller rows, so it wins ties
    if (is_tgt && in_item.last && (lbest_next > in_item.bscore)) begin
      out_next.bscore = lbest_next;
      out_next.brow   = row;
      out_next.bcol   = lcol_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_item.vld && !in_item.tgt && in_item.wr && (in_item.idx == cell_idx)) begin
      qchar <= in_item.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid       <= 1'b0;
      hleft        <= '0;
      diag         <= '0;
      lbest        <= '0;
      lcol         <= '0;
      out_item.vld <= 1'b0;
    end else if (en) begin
      out_item <= out_next;
      if (in_item.vld) begin
        if (!in_item.tgt) begin
          if (in_item.clr) begin
            hleft  <= '0;
            diag   <= '0;
            lbest  <= '0;
            lcol   <= '0;
          end
          if (in_item.wr && (in_item.idx == cell_idx)) begin
            qvalid <= 1'b1;
          end else if (in_item.clr) begin
            qvalid <= 1'b0;
          end
        end else if (in_item.last) begin
          hleft <= '0;
          diag  <= '0;
          lbest <= '0;
          lcol  <= '0;
        end else begin
          hleft <= h;
          diag  <= in_item.up;
          lbest <= lbest_next;
          lcol  <= lcol_next;
        end
      end
    end
  end

endmodule

FILE: sv/las_feed.sv
// ----------------------------------------------------------------------------
// las_feed
// Entry stage: keeps query length, column count and query state, and turns
// each accepted item into a chain item.
// ----------------------------------------------------------------------------
module las_feed (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      accept,
  input  logic                      cmd,
  input  logic [las_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  output las_pkg::las_item_t        item
);
  import las_pkg::*;

  logic [QLEN_W-1:0] qlen;
  logic [COL_W-1:0]  col_cnt;
  logic              qdone;

  logic [QLEN_W-1:0] base_len;
  logic              wr;
  logic [COL_W-1:0]  col_inc;
  las_item_t         item_next;

  always_comb begin
    base_len = qdone ? '0 : qlen;
    wr       = (base_len < QLEN_W'(MAX_QUERY));
    col_inc  = (col_cnt < COL_W'(MAX_TARGET)) ? col_cnt + COL_W'(1) : col_cnt;

    item_next        = '0;
    item_next.vld    = 1'b1;
    item_next.tgt    = cmd;
    item_next.sym    = symbol;
    item_next.last   = last;
    item_next.clr    = !cmd && qdone;
    item_next.wr     = !cmd && wr;
    item_next.idx    = base_len[QIDX_W-1:0];
    item_next.col    = col_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen     <= '0;
      col_cnt  <= '0;
      qdone    <= 1'b0;
      item.vld <= 1'b0;
    end else if (en) begin
      if (accept) begin
        item <= item_next;
        if (!cmd) begin
          qlen  <= wr ? base_len + QLEN_W'(1) : base_len;
          qdone <= last;
          if (qdone) begin
            col_cnt <= '0;
          end
        end else begin
          qdone   <= 1'b1;
          col_cnt <= last ? '0 : col_inc;
        end
      end else begin
        item.vld <= 1'b0;
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for local_alignment_score. Query and target characters
// go into the stream input. The bench keeps its own score matrix and best
// cell, and checks each result that comes out against it. Scores are set over
// APB between runs, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import las_pkg::*;

  typedef enum bit {CMD_QUERY = 1'b0, CMD_TARGET = 1'b1} cmd_e;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] sym;
    bit         last;
  } char_item_t;

  typedef struct {
    logic [9:0]  score;
    logic [6:0]  row;
    logic [11:0] col;
  } align_result_t;

  localparam int HOLD_CYCLES        = 300;
  localparam int FLUSH_CYCLES       = 80;
  localparam int SETTLE_LIMIT       = 200000;
  localparam int RANDOM_ITEMS       = 175;
  localparam int PHASES             = 7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] symbol
  logic        s_tuser = 1'b0; // [0] cmd
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [9:0] best_score, [16:10] end_row, [28:17] end_col
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  local_alignment_score uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoring state that mirrors the block
  logic [3:0]        score_match;
  logic signed [4:0] score_mismatch;
  logic signed [4:0] score_gap;
  logic [7:0]        query_chars [MAX_QUERY];
  int                column_h [MAX_QUERY];
  int                query_len;
  int                target_col;
  int                best_h;
  int                best_r;
  int                best_c;
  bit                query_closed;

  align_result_t expected_results[$];
  char_item_t    pending_chars[$];
  int            mismatches = 0;
  int            chars_queued = 0;
  logic [7:0]    seq_base = 8'h41;

  bit in_taken = 1'b0;
  int src_level = 1;
  int sink_level = 1;
  int src_gap = 0;
  int sink_stall = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;

  function automatic void clear_matrix();
    foreach (column_h[i]) column_h[i] = 0;
    target_col = 0;
    best_h = 0;
    best_r = 0;
    best_c = 0;
  endfunction

  function automatic void reset_scoring();
    score_match    = MATCH_RESET;
    score_mismatch = MISMATCH_RESET;
    score_gap      = GAP_RESET;
    query_len      = 0;
    query_closed   = 1'b0;
    clear_matrix();
  endfunction

  // one query load or one target column of the score matrix
  function automatic void score_char(char_item_t it);
    int diag, up, left, sim, h, r;
    align_result_t res;
    if (it.cmd == CMD_QUERY) begin
      // a load after a closed query starts a new one
      if (query_closed) begin
        query_closed = 1'b0;
        query_len = 0;
        clear_matrix();
      end
      if (query_len < MAX_QUERY) begin
        query_chars[query_len] = it.sym;
        query_len++;
      end
      if (it.last) query_closed = 1'b1;
    end else begin
      query_closed = 1'b1;
      if (target_col < MAX_TARGET) target_col++;
      diag = 0;
      up = 0;
      for (r = 0; r < query_len; r++) begin
        left = column_h[r];
        sim = (query_chars[r] == it.sym) ? int'(score_match) : int'(score_mismatch);
        h = 0;
        if (diag + sim > h) h = diag + sim;
        if (up + int'(score_gap) > h) h = up + int'(score_gap);
        if (left + int'(score_gap) > h) h = left + int'(score_gap);
        if (h > SCORE_MAX) h = SCORE_MAX;
        column_h[r] = h;
        diag = left;
        up = h;
        // first best cell in row-major order
        if (h > 0 && (h > best_h || (h == best_h &&
            (r + 1 < best_r || (r + 1 == best_r && target_col < best_c))))) begin
          best_h = h;
          best_r = r + 1;
          best_c = target_col;
        end
      end
      if (it.last) begin
        res.score = 10'(best_h);
        res.row   = 7'(best_r);
        res.col   = 12'(best_c);
        expected_results.insert(expected_results.size(), res);
        clear_matrix();
      end
    end
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic int gap_len(int level);
    int p;
    if (level == 0) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sampling side: register writes, accepted items, results
  always @(posedge clk) begin
    char_item_t got;
    align_result_t want;
    in_taken <= s_tvalid && s_tready;
    if (rst) begin
      reset_scoring();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MATCH:    score_match = pwdata[3:0];
          REG_MISMATCH: score_mismatch = pwdata[4:0];
          REG_GAP:      score_gap = pwdata[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        got.cmd  = cmd_e'(s_tuser);
        got.sym  = s_tdata;
        got.last = s_tlast;
        score_char(got);
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result score %0d row %0d col %0d",
                                  m_tdata[9:0], m_tdata[16:10], m_tdata[28:17]));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[9:0] !== want.score || m_tdata[16:10] !== want.row ||
              m_tdata[28:17] !== want.col)
            note_mismatch($sformatf(
              "expected score %0d row %0d col %0d, got score %0d row %0d col %0d",
              want.score, want.row, want.col,
              m_tdata[9:0], m_tdata[16:10], m_tdata[28:17]));
        end
      end
    end
  end

  // input side: hold the item until taken, then an optional gap
  always @(negedge clk) begin
    char_item_t next_in;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !in_taken)) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap--;
      end else if (pending_chars.size() > 0) begin
        next_in = pending_chars.pop_front();
        s_tuser  <= next_in.cmd;
        s_tdata  <= next_in.sym;
        s_tlast  <= next_in.last;
        s_tvalid <= 1'b1;
        src_gap = gap_len(src_level);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side: random stalls, plus one long hold on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall = gap_len(sink_level);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    logic [31:0] wd;
    wd = $urandom;
    wd[4:0] = val;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = wd;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_scores(input logic [3:0] m, input logic [4:0] mm, input logic [4:0] g);
    write_reg(REG_MATCH, {1'b0, m});
    write_reg(REG_MISMATCH, mm);
    write_reg(REG_GAP, g);
  endtask

  // wait until every item is taken and every result is back
  task automatic settle(input int extra);
    int n;
    n = 0;
    do begin
      @(posedge clk);
      #1;
      n++;
    end while ((pending_chars.size() > 0 || s_tvalid || expected_results.size() > 0) &&
               n < SETTLE_LIMIT);
    repeat (extra) @(posedge clk);
  endtask

  function automatic void push_char(cmd_e c, logic [7:0] s, bit l);
    char_item_t it;
    it.cmd  = c;
    it.sym  = s;
    it.last = l;
    pending_chars.insert(pending_chars.size(), it);
    chars_queued++;
  endfunction

  // characters near one base byte so that matches are common, or random bytes when wild
  function automatic void push_run(cmd_e c, int len, bit wild);
    int i;
    for (i = 0; i < len; i++)
      push_char(c, wild ? 8'($urandom_range(0, 255)) : 8'(seq_base ^ $urandom_range(0, 3)),
                i == len - 1);
  endfunction

  function automatic int query_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 12);
    if (p < 95) return $urandom_range(13, MAX_QUERY);
    return $urandom_range(MAX_QUERY + 1, MAX_QUERY + 8);
  endfunction

  function automatic int target_size();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
  endfunction

  function automatic void random_sequence();
    int p, n;
    bit wild;
    p = $urandom_range(0, 99);
    wild = ($urandom_range(0, 4) == 0);
    if (p < 75) begin
      seq_base = 8'($urandom_range(0, 255));
      push_run(CMD_QUERY, query_size(), wild);
      n = $urandom_range(1, 3);
      repeat (n) push_run(CMD_TARGET, target_size(), wild);
    end else if (p < 85) begin
      push_run(CMD_TARGET, target_size(), wild);
    end else begin
      // loose items: open queries, targets without an end, stray marks
      n = $urandom_range(1, 5);
      repeat (n) push_char(cmd_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
    end
  endfunction

  initial begin
    int ph, start;
    bit paused;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items at reset scores
    push_char(CMD_TARGET, 8'h00, 1'b1);   // no query at all
    push_char(CMD_QUERY, 8'h41, 1'b0);
    push_char(CMD_TARGET, 8'h41, 1'b1);   // target closes an open query
    push_char(CMD_QUERY, 8'h00, 1'b0);    // load after a closed query
    push_char(CMD_QUERY, 8'hFF, 1'b1);
    push_char(CMD_TARGET, 8'hFF, 1'b0);
    push_char(CMD_TARGET, 8'h00, 1'b1);   // tie between rows
    push_char(CMD_TARGET, 8'h55, 1'b1);   // nothing matches
    push_char(CMD_QUERY, 8'h41, 1'b0);
    push_char(CMD_QUERY, 8'h42, 1'b1);
    push_char(CMD_TARGET, 8'h42, 1'b0);
    push_char(CMD_TARGET, 8'h41, 1'b1);
    push_char(CMD_QUERY, 8'h80, 1'b0);
    push_char(CMD_QUERY, 8'h80, 1'b1);
    push_char(CMD_TARGET, 8'h80, 1'b0);
    push_char(CMD_TARGET, 8'h80, 1'b1);
    settle(FLUSH_CYCLES);

    // positive scores drive cells into saturation; the query overruns
    set_scores(4'd15, 5'sd15, 5'sd15);
    src_level = 1;
    seq_base = 8'h3C;
    push_run(CMD_QUERY, MAX_QUERY + 6, 1'b1);
    push_run(CMD_TARGET, 20, 1'b1);
    push_run(CMD_QUERY, 5, 1'b0);
    push_run(CMD_TARGET, 6, 1'b0);

    for (ph = 0; ph < PHASES; ph++) begin
      settle(FLUSH_CYCLES);
      case (ph)
        0: set_scores(MATCH_RESET, MISMATCH_RESET, GAP_RESET);
        1: set_scores(4'd0, -5'sd16, -5'sd16);
        2: set_scores(4'd15, 5'sd0, 5'sd0);
        3: set_scores(4'd15, -5'sd16, -5'sd1);
        PHASES - 1: set_scores(4'($urandom_range(0, 15)), 5'($urandom), 5'($urandom));
        default: set_scores(4'($urandom_range(0, 15)), 5'(-$urandom_range(0, 16)),
                            5'(-$urandom_range(0, 16)));
      endcase
      src_level  = (ph == 0) ? 1 : $urandom_range(0, 2) > 0;
      sink_level = (ph == 0) ? 1 : $urandom_range(0, 2) > 0;
      // long output hold while input keeps coming
      if (ph == 0) hold_go = 1'b1;
      start = chars_queued;
      paused = 1'b0;
      while (chars_queued - start < RANDOM_ITEMS / PHASES) begin
        random_sequence();
        if (!paused && chars_queued - start >= RANDOM_ITEMS / (2 * PHASES)) begin
          settle(0);
          paused = 1'b1;
        end
      end
    end

    settle(FLUSH_CYCLES);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
sv/las_pkg.sv
sv/las_cell.sv
sv/las_feed.sv
sv/local_alignment_score.sv
dv/tb_top.sv
